// ----- rtl/core/hashed_direct_mapped_id_cache_core_defines.svh -----
// ----------------------------------------------------------------------------
// Hashed ID cache assertion macros
// Concurrent assertion shorthands that compile away in synthesis.
// ----------------------------------------------------------------------------
`ifndef HASHED_DIRECT_MAPPED_ID_CACHE_CORE_DEFINES_SVH
`define HASHED_DIRECT_MAPPED_ID_CACHE_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define HDIC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle implication check failed");
`define HDIC_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle implication check failed");
`else
`define HDIC_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define HDIC_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ----- rtl/core/hdic_pkg.sv -----
// ----------------------------------------------------------------------------
// Hashed ID cache package
// Shared constants, codes and the slot entry type.
// ----------------------------------------------------------------------------
`default_nettype none

package hdic_pkg;

    localparam int SLOT_COUNT_DEF = 1024;

    localparam logic [31:0] MIX_C1 = 32'h85eb_ca6b;
    localparam logic [31:0] MIX_C2 = 32'hc2b2_ae35;

    localparam logic [31:0] LOW_BOUND_RST  = 32'h0001_0000;
    localparam logic [31:0] HIGH_BOUND_RST = 32'hFFE0_0000;

    localparam logic [1:0] REQ_LOOKUP = 2'd0;
    localparam logic [1:0] REQ_FILL   = 2'd1;
    localparam logic [1:0] REQ_INVAL  = 2'd2;

    localparam logic [1:0] STAT_NULL = 2'd0;
    localparam logic [1:0] STAT_HIT  = 2'd1;
    localparam logic [1:0] STAT_MISS = 2'd2;
    localparam logic [1:0] STAT_DONE = 2'd3;

    localparam logic CFG_LOW_BOUND  = 1'b0;
    localparam logic CFG_HIGH_BOUND = 1'b1;

    typedef struct packed {
        logic [63:0] tag;
        logic [31:0] ptr;
    } slot_entry_t;

endpackage

`default_nettype wire

// ----- rtl/core/hdic_hash.sv -----
// ----------------------------------------------------------------------------
// Hashed ID cache slot hash
// Folds the identifier, runs the fmix32 mix over registered stages and
// reduces the result to a slot index.
// ----------------------------------------------------------------------------
`default_nettype none

module hdic_hash
    import hdic_pkg::*;
#(
    parameter int SLOT_COUNT = SLOT_COUNT_DEF,
    localparam int IDX_W = $clog2(SLOT_COUNT)
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    input  wire logic [63:0]      in_id,
    output logic                  out_valid,
    output logic [IDX_W-1:0]      out_slot
);

    logic [31:0] fold;
    logic [31:0] h0_reg;
    logic [31:0] h0_next;
    logic [31:0] m1_reg;
    logic [31:0] m1_next;
    logic [31:0] x1;
    logic [31:0] m2_reg;
    logic [31:0] m2_next;
    logic [31:0] h3_reg;
    logic [31:0] h3_next;
    logic [3:0]  vld_reg;

    assign fold    = in_id[31:0] ^ in_id[63:32];
    assign h0_next = fold ^ (fold >> 16);
    assign m1_next = h0_reg * MIX_C1;
    assign x1      = m1_reg ^ (m1_reg >> 13);
    assign m2_next = x1 * MIX_C2;
    assign h3_next = m2_reg ^ (m2_reg >> 16);

    always_ff @(posedge clk)
    begin
        h0_reg <= h0_next;
        m1_reg <= m1_next;
        m2_reg <= m2_next;
        h3_reg <= h3_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[2:0], in_valid};
        end
    end

    generate
        if ((SLOT_COUNT & (SLOT_COUNT - 1)) == 0)
        begin : g_mask
            assign out_valid = vld_reg[3];
            assign out_slot  = h3_reg[IDX_W-1:0];
        end
        else
        begin : g_rem
            localparam logic [IDX_W:0] SLOT_K = (IDX_W + 1)'(SLOT_COUNT);
            localparam logic [32:0] RECIP =
                33'(((64'd1 << (32 + IDX_W)) + 64'(SLOT_COUNT) - 64'd1) / 64'(SLOT_COUNT));

            logic [31:0]       n1_reg;
            logic [31:0]       n2_reg;
            logic [63:0]       prod_lo;
            logic [64:0]       prod_reg;
            logic [64:0]       prod_next;
            logic [32-IDX_W:0] quot;
            logic [31:0]       qk_reg;
            logic [31:0]       qk_next;
            logic [31:0]       diff;
            logic [IDX_W-1:0]  rem_reg;
            logic [2:0]        stg_reg;

            // The quotient comes from a rounded-up reciprocal, which is exact for
            // every 32-bit value; the remainder is what is left after it.
            assign prod_lo   = 64'(h3_reg) * 64'(RECIP[31:0]);
            assign prod_next = {1'b0, prod_lo} + (RECIP[32] ? {1'b0, h3_reg, 32'd0} : 65'd0);
            assign quot      = prod_reg[64:32+IDX_W];
            assign qk_next   = 32'(quot) * 32'(SLOT_K);
            assign diff      = n2_reg - qk_reg;

            always_ff @(posedge clk)
            begin
                n1_reg   <= h3_reg;
                prod_reg <= prod_next;
                n2_reg   <= n1_reg;
                qk_reg   <= qk_next;
                rem_reg  <= diff[IDX_W-1:0];
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    stg_reg <= '0;
                end
                else
                begin
                    stg_reg <= {stg_reg[1:0], vld_reg[3]};
                end
            end

            assign out_valid = stg_reg[2];
            assign out_slot  = rem_reg;
        end
    endgenerate

endmodule

`default_nettype wire

// ----- rtl/core/hdic_slot_mem.sv -----
// ----------------------------------------------------------------------------
// Hashed ID cache slot memory
// Single-port-write, single-port-read store of tag and pointer per slot,
// with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module hdic_slot_mem
    import hdic_pkg::*;
#(
    parameter int SLOT_COUNT = SLOT_COUNT_DEF,
    localparam int IDX_W = $clog2(SLOT_COUNT)
)
(
    input  wire logic             clk,
    input  wire logic             wr_en,
    input  wire logic [IDX_W-1:0] wr_addr,
    input  wire slot_entry_t      wr_data,
    input  wire logic             rd_en,
    input  wire logic [IDX_W-1:0] rd_addr,
    output slot_entry_t           rd_data
);

    slot_entry_t mem [SLOT_COUNT];
    slot_entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ----- rtl/core/hashed_direct_mapped_id_cache_core.sv -----
// ----------------------------------------------------------------------------
// Hashed direct-mapped ID cache core
// Maps a 64-bit identifier to a cached 32-bit object pointer through a
// direct-mapped slot memory indexed by an fmix32 hash.
// ----------------------------------------------------------------------------
// A request beat is taken when start is high and busy is low; it carries
// req_type, obj_id and fill_pointer. One result beat follows per request:
// done is high for a single cycle with status and hit_pointer valid, and
// the receiver cannot stall it.
// The next request can be taken in the same cycle in which done is high.
// With a power-of-two SLOT_COUNT the slot is the low bits of the mix
// result; otherwise the slot remainder adds its registered steps first.
// The four-stage mix pipeline, the remainder unit and the read-modify-write
// of the slot memory lie between a request and its done beat; requests are handled one at a time.
// Configuration beats on cfg_valid/cfg_index/cfg_data are always taken.
// After reset the bounds return to their defaults and busy stays high
// while every slot is cleared; requests wait for it.
// ----------------------------------------------------------------------------
`default_nettype none
`include "hashed_direct_mapped_id_cache_core_defines.svh"

module hashed_direct_mapped_id_cache_core
    import hdic_pkg::*;
#(
    parameter int SLOT_COUNT = SLOT_COUNT_DEF
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [1:0]  req_type,
    input  wire logic [63:0] obj_id,
    input  wire logic [31:0] fill_pointer,
    output logic             done,
    output logic [1:0]       status,
    output logic [31:0]      hit_pointer,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic        cfg_index,
    input  wire logic [31:0] cfg_data
);

    localparam int IDX_W = $clog2(SLOT_COUNT);
    localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(SLOT_COUNT - 1);

    typedef enum logic [4:0] {
        S_CLEAR = 5'b00001,
        S_IDLE  = 5'b00010,
        S_HASH  = 5'b00100,
        S_READ  = 5'b01000,
        S_RESP  = 5'b10000
    } state_t;

    state_t           state_reg;
    state_t           state_next;
    logic [IDX_W-1:0] clr_cnt_reg;
    logic [IDX_W-1:0] clr_cnt_next;
    logic [IDX_W-1:0] slot_reg;
    logic [IDX_W-1:0] slot_next;
    logic [1:0]       req_reg;
    logic [63:0]      id_reg;
    logic [31:0]      fptr_reg;
    logic [31:0]      low_bound_reg;
    logic [31:0]      high_bound_reg;
    logic             done_reg;
    logic             done_next;
    logic [1:0]       status_reg;
    logic [1:0]       status_next;
    logic [31:0]      hit_ptr_reg;
    logic [31:0]      hit_ptr_next;

    logic             accept;
    logic             hash_valid;
    logic [IDX_W-1:0] hash_slot;
    logic             mem_wr_en;
    logic [IDX_W-1:0] mem_wr_addr;
    slot_entry_t      mem_wr_data;
    logic             mem_rd_en;
    slot_entry_t      mem_rd_data;
    logic             id_nz;
    logic             tag_hit;
    logic             ptr_ok;

    assign accept    = start && !busy;
    assign busy      = (state_reg != S_IDLE);
    assign cfg_ready = 1'b1;

    hdic_hash #(
        .SLOT_COUNT (SLOT_COUNT)
    ) u_hash (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (accept),
        .in_id     (obj_id),
        .out_valid (hash_valid),
        .out_slot  (hash_slot)
    );

    hdic_slot_mem #(
        .SLOT_COUNT (SLOT_COUNT)
    ) u_slot_mem (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (hash_slot),
        .rd_data (mem_rd_data)
    );

    assign id_nz   = (id_reg != '0);
    assign tag_hit = (mem_rd_data.tag == id_reg);
    assign ptr_ok  = (mem_rd_data.ptr != '0) && (mem_rd_data.ptr > low_bound_reg)
                     && (mem_rd_data.ptr < high_bound_reg);

    always_comb
    begin
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        slot_next    = slot_reg;
        mem_wr_en    = 1'b0;
        mem_wr_addr  = slot_reg;
        mem_wr_data  = '0;
        mem_rd_en    = 1'b0;
        done_next    = 1'b0;
        status_next  = STAT_NULL;
        hit_ptr_next = '0;
        case (state_reg)
            S_CLEAR:
            begin
                mem_wr_en    = 1'b1;
                mem_wr_addr  = clr_cnt_reg;
                clr_cnt_next = clr_cnt_reg + IDX_W'(1);
                if (clr_cnt_reg == LAST_SLOT)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_HASH;
                end
            end
            S_HASH:
            begin
                if (hash_valid)
                begin
                    mem_rd_en  = 1'b1;
                    slot_next  = hash_slot;
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                done_next  = 1'b1;
                state_next = S_IDLE;
                case (req_reg)
                    REQ_LOOKUP:
                    begin
                        if (id_nz)
                        begin
                            if (tag_hit)
                            begin
                                if (ptr_ok)
                                begin
                                    status_next  = STAT_HIT;
                                    hit_ptr_next = mem_rd_data.ptr;
                                end
                            end
                            else
                            begin
                                status_next = STAT_MISS;
                            end
                        end
                    end
                    REQ_FILL:
                    begin
                        status_next     = STAT_DONE;
                        mem_wr_en       = id_nz && (fptr_reg != '0);
                        mem_wr_data.tag = id_reg;
                        mem_wr_data.ptr = fptr_reg;
                    end
                    REQ_INVAL:
                    begin
                        status_next = STAT_DONE;
                        mem_wr_en   = id_nz && tag_hit;
                    end
                    default:
                    begin
                        status_next = STAT_NULL;
                    end
                endcase
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            clr_cnt_reg    <= '0;
            done_reg       <= 1'b0;
            low_bound_reg  <= LOW_BOUND_RST;
            high_bound_reg <= HIGH_BOUND_RST;
        end
        else
        begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            done_reg    <= done_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_LOW_BOUND:
                    begin
                        low_bound_reg <= cfg_data;
                    end
                    CFG_HIGH_BOUND:
                    begin
                        high_bound_reg <= cfg_data;
                    end
                    default:
                    begin
                        low_bound_reg <= low_bound_reg;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        slot_reg    <= slot_next;
        status_reg  <= status_next;
        hit_ptr_reg <= hit_ptr_next;
        if (accept)
        begin
            req_reg  <= req_type;
            id_reg   <= obj_id;
            fptr_reg <= fill_pointer;
        end
    end

    assign done        = done_reg;
    assign status      = status_reg;
    assign hit_pointer = hit_ptr_reg;

    `HDIC_ASSERT_IMP(a_done_not_busy, clk, rst_n, done, !busy)
    `HDIC_ASSERT_NXT(a_accept_busy, clk, rst_n, start && !busy, busy && !done)
    `HDIC_ASSERT_NXT(a_done_single, clk, rst_n, done, !done)
    `HDIC_ASSERT_IMP(a_ptr_zero, clk, rst_n, done && (status != STAT_HIT), hit_pointer == '0)
    `HDIC_ASSERT_IMP(a_no_write_idle, clk, rst_n, state_reg == S_IDLE, !mem_wr_en)

endmodule

`default_nettype wire

// ----- verif/hashed_direct_mapped_id_cache_core_tb.sv -----
// ----------------------------------------------------------------------------
// Hashed ID cache core testbench
// Drives lookup, fill, invalidate and unused requests into the cache core and
// checks every answer beat against a fixed answer from the directed table or
// a shadow copy of the slot memory and the pointer window. A short directed
// table comes first, then random traffic over a small pool of identifiers
// (with slot-sharing pairs) under several window settings, widest to empty.
// ----------------------------------------------------------------------------
module hashed_direct_mapped_id_cache_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import hdic_pkg::*;

    localparam int SLOTS = SLOT_COUNT_DEF;
    localparam logic [1:0] REQ_UNUSED = 2'd3;
    localparam int POOL_SIZE = 24;
    localparam int PHASE_COUNT = 6;
    localparam int ITEMS_PER_PHASE = 135;
    localparam int DRAIN_CYCLES = 20;

    localparam logic [63:0] ID_A = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] ID_B = 64'h0000_0000_0000_0001;
    localparam logic [63:0] ID_C = 64'h8000_0000_0000_0000;
    localparam logic [63:0] ID_D = 64'h0123_4567_89AB_CDEF;
    localparam logic [63:0] ID_E = 64'hFEDC_BA98_7654_3210;
    localparam logic [63:0] ID_F = ID_D ^ {2{32'h5A5A_0F0F}};

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] ptr;
    } answer_t;

    typedef struct {
        logic [1:0]  req;
        logic [63:0] id;
        logic [31:0] fptr;
        bit          fixed;
        logic [1:0]  want_status;
        logic [31:0] want_ptr;
    } stim_row_t;

    localparam int DIRECTED_ROWS = 26;

    stim_row_t directed_rows [DIRECTED_ROWS] = '{
        '{REQ_LOOKUP, 64'h0, 32'h0,          1'b1, STAT_NULL, 32'h0},
        '{REQ_LOOKUP, ID_A,  32'h0,          1'b1, STAT_MISS, 32'h0},
        '{REQ_FILL,   ID_A,  32'h1234_5678,  1'b1, STAT_DONE, 32'h0},
        '{REQ_LOOKUP, ID_A,  32'h0,          1'b1, STAT_HIT,  32'h1234_5678},
        '{REQ_FILL,   64'h0, 32'hFFFF_FFFF,  1'b1, STAT_DONE, 32'h0},
        '{REQ_FILL,   ID_B,  32'h0,          1'b1, STAT_DONE, 32'h0},
        '{REQ_LOOKUP, ID_B,  32'h0,          1'b0, STAT_NULL, 32'h0},
        '{REQ_FILL,   ID_B,  32'h0001_0000,  1'b1, STAT_DONE, 32'h0},
        '{REQ_LOOKUP, ID_B,  32'h0,          1'b1, STAT_NULL, 32'h0},
        '{REQ_FILL,   ID_C,  32'h0001_0001,  1'b1, STAT_DONE, 32'h0},
        '{REQ_LOOKUP, ID_C,  32'h0,          1'b1, STAT_HIT,  32'h0001_0001},
        '{REQ_FILL,   ID_E,  32'hFFDF_FFFF,  1'b1, STAT_DONE, 32'h0},
        '{REQ_LOOKUP, ID_E,  32'h0,          1'b1, STAT_HIT,  32'hFFDF_FFFF},
        '{REQ_FILL,   ID_E,  32'hFFE0_0000,  1'b1, STAT_DONE, 32'h0},
        '{REQ_LOOKUP, ID_E,  32'h0,          1'b1, STAT_NULL, 32'h0},
        '{REQ_FILL,   ID_D,  32'hFFFF_FFFF,  1'b1, STAT_DONE, 32'h0},
        '{REQ_LOOKUP, ID_D,  32'h0,          1'b1, STAT_NULL, 32'h0},
        '{REQ_FILL,   ID_F,  32'h0BAD_F00D,  1'b1, STAT_DONE, 32'h0},
        '{REQ_LOOKUP, ID_D,  32'h0,          1'b0, STAT_NULL, 32'h0},
        '{REQ_INVAL,  ID_D,  32'h0,          1'b1, STAT_DONE, 32'h0},
        '{REQ_LOOKUP, ID_F,  32'h0,          1'b0, STAT_NULL, 32'h0},
        '{REQ_INVAL,  ID_F,  32'h0,          1'b1, STAT_DONE, 32'h0},
        '{REQ_LOOKUP, ID_F,  32'h0,          1'b1, STAT_MISS, 32'h0},
        '{REQ_INVAL,  64'h0, 32'h0,          1'b1, STAT_DONE, 32'h0},
        '{REQ_UNUSED, ID_A,  32'hFFFF_FFFF,  1'b1, STAT_NULL, 32'h0},
        '{REQ_LOOKUP, ID_A,  32'h0,          1'b0, STAT_NULL, 32'h0}
    };

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [1:0]  req_type = REQ_LOOKUP;
    logic [63:0] obj_id = '0;
    logic [31:0] fill_pointer = '0;
    logic        done;
    logic [1:0]  status;
    logic [31:0] hit_pointer;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic        cfg_index = CFG_LOW_BOUND;
    logic [31:0] cfg_data = '0;

    logic        row_fixed = 1'b0;
    logic [1:0]  row_status = STAT_NULL;
    logic [31:0] row_ptr = '0;

    logic [63:0] shadow_tag [SLOTS];
    logic [31:0] shadow_ptr [SLOTS];
    logic [31:0] win_low = LOW_BOUND_RST;
    logic [31:0] win_high = HIGH_BOUND_RST;
    logic [63:0] id_pool [POOL_SIZE];

    answer_t     pending_answers [$];
    int          error_count = 0;
    int          accepted_count = 0;
    int          hit_count = 0;
    int          miss_count = 0;
    int          null_count = 0;

    hashed_direct_mapped_id_cache_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .req_type     (req_type),
        .obj_id       (obj_id),
        .fill_pointer (fill_pointer),
        .done         (done),
        .status       (status),
        .hit_pointer  (hit_pointer),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #5 clk = ~clk;

    function automatic int unsigned slot_index(logic [63:0] id);
        logic [31:0] h;
        h = id[63:32] ^ id[31:0];
        h = h ^ (h >> 16);
        h = h * MIX_C1;
        h = h ^ (h >> 13);
        h = h * MIX_C2;
        h = h ^ (h >> 16);
        return h % SLOTS;
    endfunction

    function automatic answer_t apply_request(logic [1:0] req, logic [63:0] id,
                                              logic [31:0] fptr);
        answer_t     ans;
        int unsigned s;
        logic [31:0] p;
        ans.status = STAT_NULL;
        ans.ptr = '0;
        s = slot_index(id);
        p = shadow_ptr[s];
        case (req)
            REQ_LOOKUP:
            begin
                if (id != '0)
                begin
                    if (shadow_tag[s] == id)
                    begin
                        if (p != '0 && p > win_low && p < win_high)
                        begin
                            ans.status = STAT_HIT;
                            ans.ptr = p;
                        end
                    end
                    else
                    begin
                        ans.status = STAT_MISS;
                    end
                end
            end
            REQ_FILL:
            begin
                if (id != '0 && fptr != '0)
                begin
                    shadow_tag[s] = id;
                    shadow_ptr[s] = fptr;
                end
                ans.status = STAT_DONE;
            end
            REQ_INVAL:
            begin
                if (id != '0 && shadow_tag[s] == id)
                begin
                    shadow_tag[s] = '0;
                    shadow_ptr[s] = '0;
                end
                ans.status = STAT_DONE;
            end
            default:
            begin
            end
        endcase
        return ans;
    endfunction

    always @(posedge clk)
    begin
        answer_t got;
        answer_t want;
        if (rst_n)
        begin
            if (done)
            begin
                got.status = status;
                got.ptr = hit_pointer;
                if (pending_answers.size() == 0)
                begin
                    $error("answer beat with no request outstanding: status %0d, hit_pointer %h",
                           got.status, got.ptr);
                    error_count++;
                end
                else
                begin
                    want = pending_answers.pop_front();
                    if (got.status != want.status)
                    begin
                        $error("status mismatch: expected %0d, actual %0d",
                               want.status, got.status);
                        error_count++;
                    end
                    if (got.ptr != want.ptr)
                    begin
                        $error("hit_pointer mismatch: expected %h, actual %h",
                               want.ptr, got.ptr);
                        error_count++;
                    end
                    case (want.status)
                        STAT_HIT:  hit_count++;
                        STAT_MISS: miss_count++;
                        STAT_NULL: null_count++;
                        default:
                        begin
                        end
                    endcase
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == CFG_LOW_BOUND)
                    win_low = cfg_data;
                else
                    win_high = cfg_data;
            end
            if (start && !busy)
            begin
                want = apply_request(req_type, obj_id, fill_pointer);
                if (row_fixed)
                begin
                    want.status = row_status;
                    want.ptr = row_ptr;
                end
                pending_answers.push_back(want);
                accepted_count++;
            end
        end
    end

    task automatic send_request(logic [1:0] req, logic [63:0] id, logic [31:0] fptr,
                                bit fixed, logic [1:0] ws, logic [31:0] wp);
        start <= 1'b1;
        req_type <= req;
        obj_id <= id;
        fill_pointer <= fptr;
        row_fixed <= fixed;
        row_status <= ws;
        row_ptr <= wp;
        do
            @(posedge clk);
        while (busy);
        @(negedge clk);
    endtask

    task automatic hold_off(int cycles);
        start <= 1'b0;
        repeat (cycles) @(negedge clk);
    endtask

    task automatic wait_quiet();
        start <= 1'b0;
        while (pending_answers.size() != 0)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_bound(logic idx, logic [31:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
    endtask

    task automatic set_window(logic [31:0] lo, logic [31:0] hi);
        write_bound(CFG_LOW_BOUND, lo);
        write_bound(CFG_HIGH_BOUND, hi);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [31:0] pick_pointer();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 10)
            return '0;
        if (r < 65 && {1'b0, win_high} > {1'b0, win_low} + 33'd1)
            return $urandom_range(win_high - 32'd1, win_low + 32'd1);
        if (r < 80)
        begin
            case ($urandom_range(3))
                0: return win_low;
                1: return win_high;
                2: return win_low + 32'd1;
                default: return win_high - 32'd1;
            endcase
        end
        return $urandom;
    endfunction

    function automatic logic [63:0] pick_id();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 8)
            return '0;
        if (r < 15)
            return {$urandom, $urandom};
        return id_pool[$urandom_range(POOL_SIZE - 1)];
    endfunction

    function automatic logic [1:0] pick_req();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 45)
            return REQ_LOOKUP;
        if (r < 75)
            return REQ_FILL;
        if (r < 92)
            return REQ_INVAL;
        return REQ_UNUSED;
    endfunction

    initial
    begin
        logic [31:0] lo;
        logic [31:0] hi;
        logic [31:0] t;
        logic [31:0] k;
        logic [1:0]  req;
        bit          quiet;
        foreach (shadow_tag[i])
        begin
            shadow_tag[i] = '0;
            shadow_ptr[i] = '0;
        end
        for (int i = 0; i < POOL_SIZE; i += 2)
        begin
            k = $urandom;
            id_pool[i] = {$urandom, $urandom};
            id_pool[i + 1] = id_pool[i] ^ {k, k};
        end

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (directed_rows[i])
        begin
            send_request(directed_rows[i].req, directed_rows[i].id, directed_rows[i].fptr,
                         directed_rows[i].fixed, directed_rows[i].want_status,
                         directed_rows[i].want_ptr);
            if ($urandom_range(99) < 13)
                hold_off($urandom_range(1, 8));
        end

        for (int phase = 0; phase < PHASE_COUNT; phase++)
        begin
            case (phase)
                0:
                begin
                    lo = 32'h0000_0000;
                    hi = 32'hFFFF_FFFF;
                end
                1:
                begin
                    lo = 32'hFFFF_FFFF;
                    hi = 32'h0000_0000;
                end
                2:
                begin
                    lo = 32'h8000_0000;
                    hi = 32'h8000_0000;
                end
                3:
                begin
                    lo = $urandom;
                    hi = $urandom;
                    if (lo > hi)
                    begin
                        t = lo;
                        lo = hi;
                        hi = t;
                    end
                end
                4:
                begin
                    lo = 32'h1000_0000;
                    hi = 32'h1000_0100;
                end
                default:
                begin
                    lo = LOW_BOUND_RST;
                    hi = HIGH_BOUND_RST;
                end
            endcase
            wait_quiet();
            set_window(lo, hi);
            quiet = (phase == 0);
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                req = pick_req();
                send_request(req, pick_id(), pick_pointer(), 1'b0, STAT_NULL, 32'h0);
                if (!quiet && $urandom_range(99) < 13)
                    hold_off($urandom_range(1, 8));
            end
        end

        wait_quiet();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Checked %0d request beats: %0d hits, %0d misses, %0d null answers,",
                 accepted_count, hit_count, miss_count, null_count);
        $display("over %0d directed rows and %0d pointer window settings.",
                 DIRECTED_ROWS, PHASE_COUNT + 1);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("Timed out with %0d answers outstanding.", pending_answers.size());
        $display("DONE: errors detected");
        $finish;
    end

endmodule
